// ===== hw/rtl/text_console_character_writer_core_macros.svh =====
// Assertion macros used by the checker of the text console writer.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_CORE_MACROS_SVH

// Same-cycle implication on the rising clock, skipped while reset is high.
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the rising clock, skipped while reset is high.
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

   // Screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELL_COUNT    = ROWS * COLUMNS;
   localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W        = $clog2(CELL_COUNT);

   // Field widths
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ACT_W  = 2;

   // Character and attribute codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_SCROLL,
      ST_FINISH
   } state_type;

   // What a sweep writes into each cell
   typedef enum logic [1:0] {
      FILL_RESET,
      FILL_ATTR,
      FILL_SCROLL
   } fill_mode_type;

   typedef struct packed {
      logic          load_item;
      logic          write_char;
      logic          read_cell;
      logic          sweep_start;
      logic          sweep_run;
      fill_mode_type fill_mode;
      logic          cur_step;
      logic          cur_newline;
      logic          cur_home;
      logic          cur_bottom;
      logic          load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             is_newline;
      logic             col_last;
      logic             row_last;
      logic             sweep_last;
   } status_type;

   // Linear cell address of a row and column
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

// ===== hw/rtl/tccw_ctrl.sv =====
module tccw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tccw_pkg::status_type status,
   output tccw_pkg::cmd_type    cmd
);

   tccw_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         tccw_pkg::ST_INIT: begin
            cmd.sweep_run = 1'b1;
            cmd.fill_mode = tccw_pkg::FILL_RESET;
            if (status.sweep_last) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         tccw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = tccw_pkg::ST_DECODE;
            end
         end
         tccw_pkg::ST_DECODE: begin
            state_in = tccw_pkg::ST_FINISH;
            case (status.action)
               tccw_pkg::ACT_PUT: begin
                  cmd.write_char = !status.is_newline;
                  // Scroll when the cursor leaves the last row
                  if (status.row_last && (status.is_newline || status.col_last)) begin
                     cmd.sweep_start = 1'b1;
                     cmd.fill_mode   = tccw_pkg::FILL_SCROLL;
                     cmd.cur_bottom  = 1'b1;
                     state_in        = tccw_pkg::ST_SCROLL;
                  end else if (status.is_newline) begin
                     cmd.cur_newline = 1'b1;
                  end else begin
                     cmd.cur_step = 1'b1;
                  end
               end
               tccw_pkg::ACT_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  cmd.fill_mode   = tccw_pkg::FILL_ATTR;
                  cmd.cur_home    = 1'b1;
                  state_in        = tccw_pkg::ST_CLEAR;
               end
               tccw_pkg::ACT_READ: begin
                  cmd.read_cell = 1'b1;
               end
               default: begin
               end
            endcase
         end
         tccw_pkg::ST_CLEAR: begin
            cmd.sweep_run = 1'b1;
            cmd.fill_mode = tccw_pkg::FILL_ATTR;
            if (status.sweep_last) begin
               state_in = tccw_pkg::ST_FINISH;
            end
         end
         tccw_pkg::ST_SCROLL: begin
            cmd.sweep_run = 1'b1;
            cmd.fill_mode = tccw_pkg::FILL_SCROLL;
            if (status.sweep_last) begin
               state_in = tccw_pkg::ST_FINISH;
            end
         end
         tccw_pkg::ST_FINISH: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/tccw_datapath.sv =====
module tccw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tccw_pkg::cmd_type             cmd,
   output tccw_pkg::status_type          status,
   input  logic [tccw_pkg::ACT_W-1:0]    item_action,
   input  logic [tccw_pkg::CHAR_W-1:0]   item_char,
   input  logic [tccw_pkg::ROW_W-1:0]    item_read_row,
   input  logic [tccw_pkg::COL_W-1:0]    item_read_col,
   input  logic                          attr_we,
   input  logic [tccw_pkg::ATTR_W-1:0]   attr_data,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_word,
   output logic [tccw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [tccw_pkg::COL_W-1:0]    rsp_cursor_col
);

   localparam int AW = tccw_pkg::ADDR_W;

   // Screen memory
   logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELL_COUNT];
   logic [tccw_pkg::CELL_W-1:0] rdata_ff;

   // Latched item
   logic [tccw_pkg::ACT_W-1:0]  action_ff;
   logic [tccw_pkg::CHAR_W-1:0] char_ff;
   logic [tccw_pkg::ROW_W-1:0]  read_row_ff;
   logic [tccw_pkg::COL_W-1:0]  read_col_ff;

   logic [tccw_pkg::ATTR_W-1:0] attr_ff;
   logic [tccw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tccw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [AW-1:0]               sweep_ff, sweep_in;

   logic                        we, re, read_in_range;
   logic [AW-1:0]               waddr, raddr;
   logic [tccw_pkg::CELL_W-1:0] wdata, blank_cell;

   assign read_in_range = (int'(read_row_ff) < tccw_pkg::ROWS) &&
                          (int'(read_col_ff) < tccw_pkg::COLUMNS);
   assign blank_cell    = {attr_ff, tccw_pkg::BLANK_CODE};

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff   <= item_action;
         char_ff     <= item_char;
         read_row_ff <= item_read_row;
         read_col_ff <= item_read_col;
      end
   end

   // Attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccw_pkg::RESET_ATTR;
      end else if (attr_we) begin
         attr_ff <= attr_data;
      end
   end

   // Cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.cur_home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.cur_bottom) begin
         row_in = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
         col_in = '0;
      end else if (cmd.cur_newline) begin
         row_in = row_ff + tccw_pkg::ROW_W'(1);
         col_in = '0;
      end else if (cmd.cur_step) begin
         if (int'(col_ff) == tccw_pkg::COLUMNS - 1) begin
            row_in = row_ff + tccw_pkg::ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + tccw_pkg::COL_W'(1);
         end
      end
   end

   // Sweep counter: restart on a new sweep, advance while running
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_start) begin
         sweep_in = '0;
      end else if (cmd.sweep_run) begin
         sweep_in = sweep_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
      end
   end

   // Write port: sweep fill or copy, else the character at the cursor
   always_comb begin
      we    = 1'b0;
      waddr = sweep_ff;
      wdata = blank_cell;
      if (cmd.sweep_run) begin
         we = 1'b1;
         case (cmd.fill_mode)
            tccw_pkg::FILL_RESET:  wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_CODE};
            tccw_pkg::FILL_ATTR:   wdata = blank_cell;
            tccw_pkg::FILL_SCROLL: begin
               wdata = (int'(sweep_ff) < tccw_pkg::LAST_ROW_BASE) ? rdata_ff : blank_cell;
            end
            default:               wdata = blank_cell;
         endcase
      end else if (cmd.write_char) begin
         we    = 1'b1;
         waddr = tccw_pkg::cell_addr(row_ff, col_ff);
         wdata = {attr_ff, char_ff};
      end
   end

   // Read port: one row ahead of the write during a scroll
   always_comb begin
      re    = 1'b0;
      raddr = tccw_pkg::cell_addr(read_row_ff, read_col_ff);
      if (cmd.read_cell) begin
         re = read_in_range;
      end else if (cmd.sweep_start && cmd.fill_mode == tccw_pkg::FILL_SCROLL) begin
         re    = 1'b1;
         raddr = AW'(tccw_pkg::COLUMNS);
      end else if (cmd.sweep_run && cmd.fill_mode == tccw_pkg::FILL_SCROLL) begin
         re    = (int'(sweep_ff) + 1) < tccw_pkg::LAST_ROW_BASE;
         raddr = AW'(int'(sweep_ff) + 1 + tccw_pkg::COLUMNS);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cell_word  <= (action_ff == tccw_pkg::ACT_READ && read_in_range) ?
                           rdata_ff : '0;
         rsp_cursor_row <= row_ff;
         rsp_cursor_col <= col_ff;
      end
   end

   assign status.action     = action_ff;
   assign status.is_newline = (char_ff == tccw_pkg::NEWLINE_CODE);
   assign status.col_last   = (int'(col_ff) == tccw_pkg::COLUMNS - 1);
   assign status.row_last   = (int'(row_ff) == tccw_pkg::ROWS - 1);
   assign status.sweep_last = (int'(sweep_ff) == tccw_pkg::CELL_COUNT - 1);

endmodule

// ===== hw/rtl/text_console_character_writer_core.sv =====
// Text console character writer: an 80 x 25 screen of 16-bit cells (attribute
// byte over character byte) with a cursor. An item is a put (newline moves to
// the next row, any other byte is stored at the cursor with the current
// attribute and the cursor advances), a clear, or a read of one cell; every
// item returns one beat with the cell read (zero unless a read in range) and
// the cursor after the item. One item is handled at a time: it is accepted in
// the idle state, decoded, and its result beat is loaded in the finish state,
// and the next item is taken only back in idle. Clear and any put that
// scrolls add, between decode and finish, a sweep over all 2000 cells of the
// single-write-port screen memory, one cell per cycle. A result beat stalled
// on rsp_tready holds the block in its finish step until it is taken. After
// reset a pass fills the screen with blanks (attribute 0x0F) and no item is
// accepted meanwhile; attribute writes on the csr channel are always taken.
module text_console_character_writer_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // req_tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: cell_word[15:0], cursor_row[20:16], cursor_col[27:21], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // text_attribute write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   logic [tccw_pkg::CELL_W-1:0] cell_word;
   logic [tccw_pkg::ROW_W-1:0]  cursor_row;
   logic [tccw_pkg::COL_W-1:0]  cursor_col;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tccw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .item_action    (req_tuser),
      .item_char      (req_tdata[7:0]),
      .item_read_row  (req_tdata[12:8]),
      .item_read_col  (req_tdata[19:13]),
      .attr_we        (csr_valid && csr_ready),
      .attr_data      (csr_data),
      .rsp_cell_word  (cell_word),
      .rsp_cursor_row (cursor_row),
      .rsp_cursor_col (cursor_col)
   );

   // Pack the result beat
   assign rsp_tdata = {4'b0000, cursor_col, cursor_row, cell_word};

endmodule

// ===== hw/rtl/tccw_checker.sv =====
`include "text_console_character_writer_core_macros.svh"

module tccw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Stalled result beat holds
   `TCCW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // One item in work: no accept right after an accept
   `TCCW_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "input accepted while an item is in work")

   // Reported cursor stays on the screen
   `TCCW_ASSERT_NOW(a_row_range, rsp_tvalid, int'(rsp_tdata[20:16]) < tccw_pkg::ROWS, "cursor row off screen")
   `TCCW_ASSERT_NOW(a_col_range, rsp_tvalid, int'(rsp_tdata[27:21]) < tccw_pkg::COLUMNS, "cursor column off screen")

endmodule

bind text_console_character_writer_core tccw_checker u_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Unused action code: the block must leave everything as it is
   localparam logic [tccw_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int HOLD_LEN     = 600;
   localparam int PHASE_ITEMS  = 55;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [tccw_pkg::ACT_W-1:0]  action;
      logic [tccw_pkg::CHAR_W-1:0] char_code;
      logic [tccw_pkg::ROW_W-1:0]  read_row;
      logic [tccw_pkg::COL_W-1:0]  read_col;
   } console_item_type;

   typedef struct packed {
      logic [tccw_pkg::CELL_W-1:0] cell_word;
      logic [tccw_pkg::ROW_W-1:0]  cursor_row;
      logic [tccw_pkg::COL_W-1:0]  cursor_col;
   } console_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   // Shadow of the screen, cursor and attribute
   logic [tccw_pkg::CELL_W-1:0] screen_shadow [tccw_pkg::CELL_COUNT];
   int unsigned                 cursor_row_shadow;
   int unsigned                 cursor_col_shadow;
   logic [tccw_pkg::ATTR_W-1:0] attr_shadow;

   console_item_type   outgoing_items [$];
   console_result_type expected_results [$];
   console_item_type   offered_item;
   console_result_type expected_beat;

   int  mismatch_count = 0;
   int  result_count   = 0;
   int  items_queued   = 0;
   int  hold_cycles    = 0;
   bit  hold_request   = 1'b0;
   bit  receiver_held  = 1'b0;
   bit  steady_mode    = 1'b0;

   text_console_character_writer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the shadow screen by one item and return the beat it should produce
   function automatic console_result_type apply_console_item(input console_item_type item);
      console_result_type rsp;
      int unsigned        i;
      rsp.cell_word = '0;
      case (item.action)
         tccw_pkg::ACT_PUT: begin
            if (item.char_code == tccw_pkg::NEWLINE_CODE) begin
               cursor_col_shadow = 0;
               cursor_row_shadow++;
            end else begin
               screen_shadow[cursor_row_shadow * tccw_pkg::COLUMNS + cursor_col_shadow] =
                  {attr_shadow, item.char_code};
               cursor_col_shadow++;
            end
            if (cursor_col_shadow >= tccw_pkg::COLUMNS) begin
               cursor_col_shadow = 0;
               cursor_row_shadow++;
            end
            // scroll up one row and blank the bottom row
            if (cursor_row_shadow >= tccw_pkg::ROWS) begin
               for (i = 0; i < tccw_pkg::LAST_ROW_BASE; i++)
                  screen_shadow[i] = screen_shadow[i + tccw_pkg::COLUMNS];
               for (i = 0; i < tccw_pkg::COLUMNS; i++)
                  screen_shadow[tccw_pkg::LAST_ROW_BASE + i] =
                     {attr_shadow, tccw_pkg::BLANK_CODE};
               cursor_col_shadow = 0;
               cursor_row_shadow = tccw_pkg::ROWS - 1;
            end
         end
         tccw_pkg::ACT_CLEAR: begin
            for (i = 0; i < tccw_pkg::CELL_COUNT; i++)
               screen_shadow[i] = {attr_shadow, tccw_pkg::BLANK_CODE};
            cursor_row_shadow = 0;
            cursor_col_shadow = 0;
         end
         tccw_pkg::ACT_READ: begin
            if (item.read_row < tccw_pkg::ROWS && item.read_col < tccw_pkg::COLUMNS)
               rsp.cell_word =
                  screen_shadow[item.read_row * tccw_pkg::COLUMNS + item.read_col];
         end
         default: begin
         end
      endcase
      rsp.cursor_row = cursor_row_shadow[tccw_pkg::ROW_W-1:0];
      rsp.cursor_col = cursor_col_shadow[tccw_pkg::COL_W-1:0];
      return rsp;
   endfunction

   function automatic bit take_gap();
      return !steady_mode && ($urandom_range(0, 99) < 32);
   endfunction

   // Mostly in range when a read wants it, otherwise any value of the field
   function automatic logic [tccw_pkg::ROW_W-1:0] pick_row(input bit on_screen);
      if (on_screen && $urandom_range(0, 99) < 85)
         return tccw_pkg::ROW_W'($urandom_range(0, tccw_pkg::ROWS - 1));
      return tccw_pkg::ROW_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [tccw_pkg::COL_W-1:0] pick_col(input bit on_screen);
      if (on_screen && $urandom_range(0, 99) < 85)
         return tccw_pkg::COL_W'($urandom_range(0, tccw_pkg::COLUMNS - 1));
      return tccw_pkg::COL_W'($urandom_range(0, 127));
   endfunction

   task automatic queue_item(input logic [tccw_pkg::ACT_W-1:0]  act,
                             input logic [tccw_pkg::CHAR_W-1:0] ch,
                             input logic [tccw_pkg::ROW_W-1:0]  row,
                             input logic [tccw_pkg::COL_W-1:0]  col);
      console_item_type item;
      item.action    = act;
      item.char_code = ch;
      item.read_row  = row;
      item.read_col  = col;
      outgoing_items.push_back(item);
      items_queued++;
   endtask

   task automatic queue_put(input logic [tccw_pkg::CHAR_W-1:0] ch);
      queue_item(tccw_pkg::ACT_PUT, ch, pick_row(1'b0), pick_col(1'b0));
   endtask

   // One burst of random traffic: text runs dominate so the cursor walks and scrolls
   task automatic queue_random_burst();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         len = $urandom_range(1, 40);
         repeat (len)
            queue_put(($urandom_range(0, 99) < 5) ? tccw_pkg::NEWLINE_CODE
                                                  : tccw_pkg::CHAR_W'($urandom_range(0, 255)));
      end else if (kind < 55) begin
         len = $urandom_range(1, 6);
         repeat (len) queue_put(tccw_pkg::NEWLINE_CODE);
      end else if (kind < 85) begin
         len = $urandom_range(1, 8);
         repeat (len)
            queue_item(tccw_pkg::ACT_READ, tccw_pkg::CHAR_W'($urandom_range(0, 255)),
                       pick_row(1'b1), pick_col(1'b1));
      end else if (kind < 90) begin
         queue_item(tccw_pkg::ACT_CLEAR, tccw_pkg::CHAR_W'($urandom_range(0, 255)),
                    pick_row(1'b0), pick_col(1'b0));
      end else begin
         len = $urandom_range(1, 3);
         repeat (len)
            queue_item(($urandom_range(0, 1) != 0) ? ACT_UNUSED
                                                   : tccw_pkg::ACT_W'($urandom_range(0, 3)),
                       tccw_pkg::CHAR_W'($urandom_range(0, 255)), pick_row(1'b0),
                       pick_col(1'b0));
      end
   endtask

   // Write the attribute register; call only while the block is idle
   task automatic write_attribute(input logic [tccw_pkg::ATTR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      attr_shadow = value;
      csr_valid <= 1'b0;
   endtask

   // Hold until every item is out and every result is back, then let the block settle
   task automatic wait_for_idle();
      while (outgoing_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Request driver: predict each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_console_item(offered_item));
         end
         if (!req_tvalid || req_tready) begin
            if (outgoing_items.size() != 0 && !take_gap()) begin
               offered_item = outgoing_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'd0, offered_item.read_col, offered_item.read_row,
                              offered_item.char_code};
               req_tuser  <= offered_item.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver hold-off: one long stretch of stalled results
   always @(posedge clock) begin
      if (hold_request && hold_cycles < HOLD_LEN) begin
         receiver_held <= 1'b1;
         hold_cycles   <= hold_cycles + 1;
      end else begin
         receiver_held <= 1'b0;
      end
   end

   // Result monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d: unexpected beat %h", result_count, rsp_tdata);
            end else begin
               expected_beat = expected_results.pop_front();
               if (rsp_tdata[15:0] !== expected_beat.cell_word ||
                   rsp_tdata[20:16] !== expected_beat.cursor_row ||
                   rsp_tdata[27:21] !== expected_beat.cursor_col) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"result %0d: expected cell %h row %0d col %0d,",
                               " got cell %h row %0d col %0d"},
                              result_count, expected_beat.cell_word,
                              expected_beat.cursor_row, expected_beat.cursor_col,
                              rsp_tdata[15:0], rsp_tdata[20:16], rsp_tdata[27:21]);
               end
            end
         end
         rsp_tready <= !receiver_held && !take_gap();
      end
   end

   // Stimulus and end of run
   initial begin
      logic [tccw_pkg::ATTR_W-1:0] phase_attr [4];
      int                          phase_end;
      bit                          paused;
      for (int i = 0; i < tccw_pkg::CELL_COUNT; i++)
         screen_shadow[i] = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_CODE};
      cursor_row_shadow = 0;
      cursor_col_shadow = 0;
      attr_shadow       = tccw_pkg::RESET_ATTR;
      phase_attr[0] = 8'hFF;
      phase_attr[1] = tccw_pkg::ATTR_W'($urandom_range(0, 255));
      phase_attr[2] = tccw_pkg::ATTR_W'($urandom_range(0, 255));
      phase_attr[3] = tccw_pkg::ATTR_W'($urandom_range(0, 255));
      paused = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: blank screen after reset, reads off the screen, extreme bytes
      write_attribute(8'h00);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
      queue_item(tccw_pkg::ACT_READ, 8'hFF, 5'd24, 7'd79);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd25, 7'd0);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd80);
      queue_item(tccw_pkg::ACT_READ, 8'hFF, 5'd31, 7'd127);
      queue_put(8'h00);
      queue_put(8'hFF);
      queue_put(8'h41);
      queue_item(ACT_UNUSED, 8'hFF, 5'd31, 7'd127);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd1);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd2);
      queue_put(tccw_pkg::NEWLINE_CODE);
      queue_put(8'h7F);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd1, 7'd0);
      queue_item(tccw_pkg::ACT_CLEAR, 8'hFF, 5'd31, 7'd127);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd0, 7'd0);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd1, 7'd0);
      queue_item(tccw_pkg::ACT_READ, 8'h00, 5'd24, 7'd79);
      wait_for_idle();

      // Random phases, each under its own attribute
      for (int phase = 0; phase < 4; phase++) begin
         write_attribute(phase_attr[phase]);
         steady_mode <= (phase == 1);
         if (phase == 0) begin
            // stall the receiver while a text run keeps the sender busy
            hold_request <= 1'b1;
            repeat (12) queue_put(tccw_pkg::CHAR_W'($urandom_range(0, 255)));
            // climb to the last row and scroll with newlines
            repeat (26) queue_put(tccw_pkg::NEWLINE_CODE);
         end
         phase_end = items_queued + PHASE_ITEMS;
         while (items_queued < phase_end) begin
            queue_random_burst();
            if (phase == 2 && !paused && items_queued >= phase_end - PHASE_ITEMS / 2) begin
               wait_for_idle();
               paused = 1'b1;
            end
         end
         wait_for_idle();
      end

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
